### rtl/balance_and_line_follow_pid_unit_assert.svh
// Assertion macros shared by the checker of the balance and line follow PID unit.
// Depends on nothing; include with the bare file name.
`ifndef BALANCE_AND_LINE_FOLLOW_PID_UNIT_ASSERT_SVH
`define BALANCE_AND_LINE_FOLLOW_PID_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BLF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define BLF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/blf_pid_pkg.sv
// Package for the balance and line follow PID unit: types, constants, helpers.
// Used by the controller, datapath and top level.
`timescale 1ns / 1ps
package blf_pid_pkg;
   localparam int Q168_MAX = 8388607;
   localparam int Q168_MIN = -8388608;
   localparam int AREA_LIM = 217600;
   localparam int CMD_MAX = 23040;
   localparam int PWM_HI = 16640;
   localparam int PWM_LO = 11520;
   localparam int BOOST = 3840;
   localparam int BOOST_GATE = 21760;
   localparam int YAW_INT_LIM = 7680;
   localparam int LOST_ERR = 6400;
   localparam int TURN_LEVEL = 2560;
   localparam int LINE_LEVEL = 700;
   localparam int SCALE_TOP = 1000;
   localparam int SENSOR_COUNT = 5;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_BACK = 2'd2;

   localparam logic [2:0] REG_PGP = 3'd0;
   localparam logic [2:0] REG_PGI = 3'd1;
   localparam logic [2:0] REG_PGD = 3'd2;
   localparam logic [2:0] REG_YGP = 3'd3;
   localparam logic [2:0] REG_YGI = 3'd4;
   localparam logic [2:0] REG_YGD = 3'd5;
   localparam logic [2:0] REG_PTGT = 3'd6;
   localparam logic [2:0] REG_FBM = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SENSE, ST_DIVIDE, ST_YAW, ST_PITCH, ST_FINISH, ST_OUTPUT
   } state_type;

   // Multiply-accumulate operand selects.
   typedef enum logic [2:0] {
      MAC_YP, MAC_YI, MAC_YD, MAC_PP, MAC_PI, MAC_PD
   } mac_sel_type;

   typedef struct packed {
      logic load;
      logic sense_step;
      logic div_start;
      logic div_step;
      logic yaw_prep;
      logic mac_clear;
      logic mac_en;
      mac_sel_type mac_sel;
      logic yaw_close;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic sense_done;
      logic div_done;
   } status_type;

   function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
      logic signed [31:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // Floor shift by 8 of the 50-bit accumulator, saturated to Q16.8.
   function automatic logic signed [23:0] sat_q168(input logic signed [49:0] acc);
      logic signed [41:0] s;
      logic signed [23:0] r;
      s = acc[49:8];
      r = s[23:0];
      if (s > 42'sd8388607) r = 24'sh7fffff;
      else if (s < -42'sd8388608) r = 24'sh800000;
      return r;
   endfunction
endpackage

### rtl/blf_pid_ctrl.sv
// Controller state machine of the balance and line follow PID unit.
// Depends on blf_pid_pkg.
`timescale 1ns / 1ps
module blf_pid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   rsp_busy,
   input  blf_pid_pkg::status_type status,
   output blf_pid_pkg::cmd_type    cmd,
   output logic                   idle,
   output logic                   rsp_load
);
   blf_pid_pkg::state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blf_pid_pkg::ST_IDLE;
         cnt_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         blf_pid_pkg::ST_IDLE: begin
            if (req_fire) state_in = blf_pid_pkg::ST_SENSE;
         end
         blf_pid_pkg::ST_SENSE: begin
            if (status.sense_done) state_in = blf_pid_pkg::ST_DIVIDE;
         end
         blf_pid_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = blf_pid_pkg::ST_YAW;
               cnt_in = 3'd0;
            end
         end
         blf_pid_pkg::ST_YAW: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               state_in = blf_pid_pkg::ST_PITCH;
               cnt_in = 3'd0;
            end
         end
         blf_pid_pkg::ST_PITCH: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) state_in = blf_pid_pkg::ST_FINISH;
         end
         blf_pid_pkg::ST_FINISH: state_in = blf_pid_pkg::ST_OUTPUT;
         blf_pid_pkg::ST_OUTPUT: begin
            if (!rsp_busy) state_in = blf_pid_pkg::ST_IDLE;
         end
         default: state_in = blf_pid_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mac_sel = blf_pid_pkg::MAC_YP;
      idle = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         blf_pid_pkg::ST_IDLE: begin
            idle = 1'b1;
            cmd.load = req_fire;
         end
         blf_pid_pkg::ST_SENSE: begin
            cmd.sense_step = 1'b1;
            cmd.div_start = status.sense_done;
         end
         blf_pid_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.yaw_prep = status.div_done;
            cmd.mac_clear = status.div_done;
         end
         blf_pid_pkg::ST_YAW: begin
            cmd.mac_en = (cnt_ff != 3'd3);
            case (cnt_ff)
               3'd0: cmd.mac_sel = blf_pid_pkg::MAC_YP;
               3'd1: cmd.mac_sel = blf_pid_pkg::MAC_YI;
               default: cmd.mac_sel = blf_pid_pkg::MAC_YD;
            endcase
            cmd.yaw_close = (cnt_ff == 3'd3);
            cmd.mac_clear = (cnt_ff == 3'd3);
         end
         blf_pid_pkg::ST_PITCH: begin
            cmd.mac_en = (cnt_ff != 3'd3);
            case (cnt_ff)
               3'd0: cmd.mac_sel = blf_pid_pkg::MAC_PP;
               3'd1: cmd.mac_sel = blf_pid_pkg::MAC_PI;
               default: cmd.mac_sel = blf_pid_pkg::MAC_PD;
            endcase
         end
         blf_pid_pkg::ST_FINISH: cmd.finish = 1'b1;
         blf_pid_pkg::ST_OUTPUT: rsp_load = !rsp_busy;
         default: ;
      endcase
   end
endmodule

### rtl/blf_pid_dp.sv
// Datapath of the balance and line follow PID unit: sensor scan, divider,
// shared multiply-accumulate, PID state and motor mixing. Depends on blf_pid_pkg.
`timescale 1ns / 1ps
module blf_pid_dp #(
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic                   clock,
   input  logic                   reset,
   input  blf_pid_pkg::cmd_type    cmd,
   output blf_pid_pkg::status_type status,
   input  logic [15:0]            tilt_data,
   input  logic [59:0]            sensors,
   input  logic                   csr_wen,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   output logic [1:0]             drive_direction,
   output logic [14:0]            right_duty,
   output logic [14:0]            left_duty,
   output logic                   is_balanced
);
   logic [15:0] pgp_ff, pgi_ff, pgd_ff, ygp_ff, ygi_ff, ygd_ff;
   logic signed [15:0] ptgt_ff;
   logic [14:0] fbm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pgp_ff <= 16'd2560;
         pgi_ff <= 16'd0;
         pgd_ff <= 16'd1792;
         ygp_ff <= 16'd1434;
         ygi_ff <= 16'd0;
         ygd_ff <= 16'd435;
         ptgt_ff <= 16'sd0;
         fbm_ff <= 15'd4608;
      end else if (csr_wen) begin
         case (csr_index)
            blf_pid_pkg::REG_PGP: pgp_ff <= csr_wdata;
            blf_pid_pkg::REG_PGI: pgi_ff <= csr_wdata;
            blf_pid_pkg::REG_PGD: pgd_ff <= csr_wdata;
            blf_pid_pkg::REG_YGP: ygp_ff <= csr_wdata;
            blf_pid_pkg::REG_YGI: ygi_ff <= csr_wdata;
            blf_pid_pkg::REG_YGD: ygd_ff <= csr_wdata;
            blf_pid_pkg::REG_PTGT: ptgt_ff <= csr_wdata;
            blf_pid_pkg::REG_FBM: fbm_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Input capture and sensor scan, one sensor per cycle.
   // The scaled reading is compared with the line level without a divide.
   localparam int DARK_BOUND = (blf_pid_pkg::SCALE_TOP - blf_pid_pkg::LINE_LEVEL)
                               * ADC_FULL_SCALE;
   localparam int LIGHT_BOUND = DARK_BOUND + ADC_FULL_SCALE;
   logic signed [15:0] angle_ff;
   logic [59:0] sens_ff;
   logic [2:0] sidx_ff;
   logic mark_ff, seen_ff;
   logic signed [6:0] wsum_ff;
   logic [2:0] scnt_ff;
   logic [11:0] raw;
   logic [15:0] rclamp;
   logic [31:0] prod;
   logic signed [6:0] weight;
   logic mark_now;

   assign raw = sens_ff[11:0];
   always_comb begin
      rclamp = {4'd0, raw};
      if (32'(raw) > 32'(ADC_FULL_SCALE)) rclamp = 16'(ADC_FULL_SCALE);
      prod = 32'(rclamp) * 32'(blf_pid_pkg::SCALE_TOP);
      mark_now = mark_ff;
      if (prod < 32'(DARK_BOUND)) mark_now = 1'b1;
      else if (prod >= 32'(LIGHT_BOUND)) mark_now = 1'b0;
      case (sidx_ff)
         3'd0: weight = -7'sd5;
         3'd1: weight = -7'sd3;
         3'd2: weight = 7'sd1;
         3'd3: weight = 7'sd3;
         default: weight = 7'sd5;
      endcase
   end
   assign status.sense_done = cmd.sense_step && (sidx_ff == 3'(blf_pid_pkg::SENSOR_COUNT));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         angle_ff <= tilt_data;
         sens_ff <= sensors;
         sidx_ff <= 3'd0;
         mark_ff <= 1'b0;
         seen_ff <= 1'b0;
         wsum_ff <= 7'sd0;
         scnt_ff <= 3'd0;
      end else if (cmd.sense_step && sidx_ff != 3'(blf_pid_pkg::SENSOR_COUNT)) begin
         sens_ff <= {12'd0, sens_ff[59:12]};
         sidx_ff <= sidx_ff + 3'd1;
         mark_ff <= mark_now;
         if (mark_now) begin
            seen_ff <= 1'b1;
            wsum_ff <= wsum_ff + weight;
            scnt_ff <= scnt_ff + 3'd1;
         end
      end
   end

   // Restoring divider: |(wsum-1)*2560| / count, one quotient bit per cycle.
   logic [15:0] dnum_ff, dquo_ff;
   logic [2:0] drem_ff;
   logic [4:0] dcnt_ff;
   logic dneg_ff;
   logic signed [7:0] wm1;
   logic signed [19:0] numer;
   logic [3:0] trial;
   assign wm1 = 8'(wsum_ff) - 8'sd1;
   assign numer = 20'(wm1) * 20'sd2560;
   assign trial = {drem_ff, dnum_ff[15]};
   assign status.div_done = cmd.div_step && (dcnt_ff == 5'd16);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dneg_ff <= numer[19];
         dnum_ff <= numer[19] ? 16'(-numer) : numer[15:0];
         drem_ff <= 3'd0;
         dquo_ff <= 16'd0;
         dcnt_ff <= 5'd0;
      end else if (cmd.div_step && dcnt_ff != 5'd16) begin
         dnum_ff <= {dnum_ff[14:0], 1'b0};
         dcnt_ff <= dcnt_ff + 5'd1;
         if (scnt_ff != 3'd0 && trial >= {1'b0, scnt_ff}) begin
            drem_ff <= 3'(trial - {1'b0, scnt_ff});
            dquo_ff <= {dquo_ff[14:0], 1'b1};
         end else begin
            drem_ff <= trial[2:0];
            dquo_ff <= {dquo_ff[14:0], 1'b0};
         end
      end
   end

   // PID state and shared multiply-accumulate.
   logic bal_ff;
   logic signed [23:0] lpe_ff, lye_ff, yint_ff, yerr_ff, ydiff_ff, ycorr_ff;
   logic signed [23:0] perr_ff, pdiff_ff;
   logic signed [31:0] pint_ff;
   logic signed [49:0] acc_ff;
   logic signed [23:0] yerr_in;
   logic signed [31:0] yint_sum;
   logic signed [32:0] pint_sum;
   logic signed [31:0] pint_in;
   logic signed [23:0] perr_in, pdiff_raw;
   logic [15:0] mgain;
   logic signed [31:0] mterm;
   logic signed [48:0] mprod;

   always_comb begin
      if (!seen_ff) yerr_in = (lye_ff > 0) ? 24'(blf_pid_pkg::LOST_ERR)
                                           : -24'(blf_pid_pkg::LOST_ERR);
      else yerr_in = dneg_ff ? -24'(dquo_ff) : 24'(dquo_ff);
      yint_sum = 32'(yint_ff) + 32'(yerr_in);
      perr_in = 24'(ptgt_ff) - 24'(angle_ff);
      pdiff_raw = perr_in - lpe_ff;
      pint_sum = 33'(pint_ff) + 33'(perr_in);
      pint_in = pint_sum[31:0];
      if (pint_sum > 33'sd2147483647) pint_in = 32'sh7fffffff;
      else if (pint_sum < -33'sd2147483648) pint_in = 32'sh80000000;
      case (cmd.mac_sel)
         blf_pid_pkg::MAC_YP: begin mgain = ygp_ff; mterm = 32'(yerr_ff); end
         blf_pid_pkg::MAC_YI: begin mgain = ygi_ff; mterm = 32'(yint_ff); end
         blf_pid_pkg::MAC_YD: begin mgain = ygd_ff; mterm = 32'(ydiff_ff); end
         blf_pid_pkg::MAC_PP: begin mgain = pgp_ff; mterm = 32'(perr_ff); end
         blf_pid_pkg::MAC_PI: begin
            mgain = pgi_ff;
            mterm = blf_pid_pkg::clamp32(pint_ff, -32'(blf_pid_pkg::AREA_LIM),
                                         32'(blf_pid_pkg::AREA_LIM));
         end
         default: begin
            mgain = pgd_ff;
            mterm = blf_pid_pkg::clamp32(32'(pdiff_ff), -32'(blf_pid_pkg::AREA_LIM),
                                         32'(blf_pid_pkg::AREA_LIM));
         end
      endcase
      mprod = $signed({1'b0, mgain}) * 49'(mterm);
   end

   // Output mixing.
   logic signed [23:0] pcorr;
   logic signed [31:0] cmdv, pwm, rgt, lft;
   logic [1:0] dir_in;
   logic bal_in;
   always_comb begin
      pcorr = blf_pid_pkg::sat_q168(acc_ff);
      cmdv = (pcorr < 0) ? -32'(pcorr) : 32'(pcorr);
      if (cmdv > 32'(blf_pid_pkg::CMD_MAX)) cmdv = 32'(blf_pid_pkg::CMD_MAX);
      pwm = blf_pid_pkg::clamp32(cmdv, 32'(blf_pid_pkg::PWM_LO), 32'(blf_pid_pkg::PWM_HI));
      bal_in = bal_ff;
      if (!bal_ff) begin
         rgt = pwm;
         lft = pwm;
         if (perr_ff > 24'sd256) dir_in = blf_pid_pkg::DIR_BACK;
         else if (perr_ff < -24'sd256) dir_in = blf_pid_pkg::DIR_FWD;
         else begin
            dir_in = blf_pid_pkg::DIR_STOP;
            rgt = 32'sd0;
            lft = 32'sd0;
            bal_in = 1'b1;
         end
      end else begin
         dir_in = blf_pid_pkg::DIR_FWD;
         rgt = blf_pid_pkg::clamp32(cmdv - 32'(ycorr_ff), 32'(blf_pid_pkg::PWM_LO),
                                    32'(blf_pid_pkg::PWM_HI));
         lft = blf_pid_pkg::clamp32(cmdv + 32'(ycorr_ff), 32'(blf_pid_pkg::PWM_LO),
                                    32'(blf_pid_pkg::PWM_HI));
         if (yerr_ff > 24'(blf_pid_pkg::TURN_LEVEL)
             && rgt <= 32'(blf_pid_pkg::BOOST_GATE)) begin
            rgt = rgt + 32'(blf_pid_pkg::BOOST);
            lft = lft - 32'(blf_pid_pkg::BOOST);
         end else if (yerr_ff < -24'(blf_pid_pkg::TURN_LEVEL)
                      && lft <= 32'(blf_pid_pkg::BOOST_GATE)) begin
            lft = lft + 32'(blf_pid_pkg::BOOST);
            rgt = rgt - 32'(blf_pid_pkg::BOOST);
         end
         if (-32'(perr_ff) > 32'(fbm_ff) || perr_ff > 0) bal_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff <= 1'b0;
         lpe_ff <= '0;
         lye_ff <= '0;
         yint_ff <= '0;
         pint_ff <= '0;
      end else begin
         if (cmd.yaw_prep) begin
            yerr_ff <= yerr_in;
            ydiff_ff <= yerr_in - lye_ff;
            yint_ff <= 24'(blf_pid_pkg::clamp32(yint_sum, -32'(blf_pid_pkg::YAW_INT_LIM),
                                                32'(blf_pid_pkg::YAW_INT_LIM)));
            lye_ff <= yerr_in;
            perr_ff <= perr_in;
            pdiff_ff <= pdiff_raw;
            pint_ff <= pint_in;
            lpe_ff <= perr_in;
         end
         if (cmd.finish) bal_ff <= bal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_clear) acc_ff <= '0;
      else if (cmd.mac_en) acc_ff <= acc_ff + 50'(mprod);
      if (cmd.yaw_close) ycorr_ff <= blf_pid_pkg::sat_q168(acc_ff);
      if (cmd.finish) begin
         drive_direction <= dir_in;
         right_duty <= rgt[14:0];
         left_duty <= lft[14:0];
      end
   end
   assign is_balanced = bal_ff;
endmodule

### rtl/balance_and_line_follow_pid_unit.sv
// Each item passes in order through the sensor scan, the serial divider, the yaw
// and pitch multiply-accumulate steps and the output stage. A new item is taken
// only once the previous result is loaded for output, as the serial divider and the
// single shared multiplier serve one item at a time. Synchronous active-high reset
// restores register defaults and clears all controller state.
// Top level; depends on blf_pid_pkg, blf_pid_ctrl and blf_pid_dp.
`timescale 1ns / 1ps
module balance_and_line_follow_pid_unit #(
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tilt[15:0], sensor_a..sensor_e 12 bits each from bit 16, zero pad.
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive_direction[1:0], right_duty[16:2], left_duty[31:17], is_balanced[32], pad.
   output logic [39:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   blf_pid_pkg::cmd_type cmd;
   blf_pid_pkg::status_type status;
   logic idle, rsp_load, req_fire;
   logic [1:0] dir;
   logic [14:0] rd, ld;
   logic bal;
   logic vld_ff;
   logic [32:0] data_ff;

   assign req_tready = idle;
   assign req_fire = req_tvalid && idle;

   blf_pid_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .rsp_busy(vld_ff && !rsp_tready), .status(status), .cmd(cmd),
      .idle(idle), .rsp_load(rsp_load)
   );

   blf_pid_dp #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .tilt_data(req_tdata[15:0]), .sensors(req_tdata[75:16]),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .drive_direction(dir), .right_duty(rd), .left_duty(ld), .is_balanced(bal)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (rsp_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (rsp_load) data_ff <= {bal, ld, rd, dir};
   end
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {7'd0, data_ff};
endmodule

### rtl/blf_pid_checker.sv
// Port-level checker for the balance and line follow PID unit, bound to the top.
// Depends on balance_and_line_follow_pid_unit_assert.svh and blf_pid_pkg.
`timescale 1ns / 1ps
`include "balance_and_line_follow_pid_unit_assert.svh"
module blf_pid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   `BLF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BLF_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `BLF_ASSERT_IMP(a_dir_legal, clock, reset, rsp_tvalid, rsp_tdata[1:0] <= blf_pid_pkg::DIR_BACK)
   `BLF_ASSERT_IMP(a_stop_zero, clock, reset, rsp_tvalid && rsp_tdata[1:0] == blf_pid_pkg::DIR_STOP, rsp_tdata[31:2] == 30'd0 && rsp_tdata[32])
endmodule

bind balance_and_line_follow_pid_unit blf_pid_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

### tb/balance_and_line_follow_pid_unit_tb.sv
// Testbench for the balance and line follow PID unit: drives control ticks on the
// request stream, predicts each result and checks the response stream field by field.
// Depends on blf_pid_pkg and balance_and_line_follow_pid_unit.
`timescale 1ns / 1ps
module balance_and_line_follow_pid_unit_tb;
   typedef struct packed {
      logic [1:0]  dir;
      logic [14:0] right;
      logic [14:0] left;
      logic        bal;
   } drive_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic csr_wen = 0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   balance_and_line_follow_pid_unit DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   longint gp, gi, gd, yp, yi, yd, ptgt, fbm;
   logic flag;
   longint last_perr, pint, last_yerr, yint;

   logic [79:0] tick_queue[$];
   drive_type drive_queue[$];
   int errors = 0;
   bit calm = 0;
   bit stall_go = 0;
   bit hold = 0;

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint pid_total(longint s);
      longint f;
      f = s >>> 8;
      return clampl(f, blf_pid_pkg::Q168_MIN, blf_pid_pkg::Q168_MAX);
   endfunction

   function automatic drive_type predict_drive(logic [79:0] d);
      drive_type o;
      longint angle, mark, ws, cnt, r, lvl, ye, ydiff, yc, e, df, pc, cmd, rt, lt, pwm;
      bit seen;
      int w[5] = '{-5, -3, 1, 3, 5};
      angle = $signed(d[15:0]);
      mark = 0; ws = 0; cnt = 0; seen = 0;
      for (int i = 0; i < 5; i++) begin
         r = d[16 + 12 * i +: 12];
         if (r > 4095) r = 4095;
         lvl = 1000 - r * 1000 / 4095;
         if (lvl > 700) begin
            mark = 1; seen = 1;
         end else if (lvl < 700) begin
            mark = 0;
         end
         ws += w[i] * mark;
         cnt += mark;
      end
      if (!seen || cnt == 0)
         ye = last_yerr > 0 ? blf_pid_pkg::LOST_ERR : -blf_pid_pkg::LOST_ERR;
      else ye = (ws - 1) * 2560 / cnt;
      ydiff = ye - last_yerr;
      yint = clampl(yint + ye, -blf_pid_pkg::YAW_INT_LIM, blf_pid_pkg::YAW_INT_LIM);
      yc = pid_total(yp * ye + yi * yint + yd * ydiff);
      last_yerr = ye;
      e = ptgt - angle;
      df = e - last_perr;
      pint = clampl(pint + e, -64'sd2147483648, 64'sd2147483647);
      pc = pid_total(gp * e
                     + gi * clampl(pint, -blf_pid_pkg::AREA_LIM, blf_pid_pkg::AREA_LIM)
                     + gd * clampl(df, -blf_pid_pkg::AREA_LIM, blf_pid_pkg::AREA_LIM));
      last_perr = e;
      cmd = clampl(pc < 0 ? -pc : pc, 0, blf_pid_pkg::CMD_MAX);
      if (!flag) begin
         pwm = clampl(cmd, blf_pid_pkg::PWM_LO, blf_pid_pkg::PWM_HI);
         if (e > 256) begin
            o.dir = blf_pid_pkg::DIR_BACK; rt = pwm; lt = pwm;
         end else if (e < -256) begin
            o.dir = blf_pid_pkg::DIR_FWD; rt = pwm; lt = pwm;
         end else begin
            o.dir = blf_pid_pkg::DIR_STOP; rt = 0; lt = 0; flag = 1;
         end
      end else begin
         o.dir = blf_pid_pkg::DIR_FWD;
         rt = clampl(cmd - yc, blf_pid_pkg::PWM_LO, blf_pid_pkg::PWM_HI);
         lt = clampl(cmd + yc, blf_pid_pkg::PWM_LO, blf_pid_pkg::PWM_HI);
         if (ye > blf_pid_pkg::TURN_LEVEL && rt <= blf_pid_pkg::BOOST_GATE) begin
            rt += blf_pid_pkg::BOOST; lt -= blf_pid_pkg::BOOST;
         end else if (ye < -blf_pid_pkg::TURN_LEVEL && lt <= blf_pid_pkg::BOOST_GATE) begin
            lt += blf_pid_pkg::BOOST; rt -= blf_pid_pkg::BOOST;
         end
         if (-e > fbm || e > 0) flag = 0;
      end
      o.right = rt[14:0];
      o.left = lt[14:0];
      o.bal = flag;
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            drive_queue.push_back(predict_drive(req_tdata));
            void'(tick_queue.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1;
         end else if (tick_queue.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            req_tvalid <= 1;
            req_tdata <= tick_queue[0];
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      drive_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[1:0], rsp_tdata[16:2], rsp_tdata[31:17], rsp_tdata[32]};
            if (drive_queue.size() == 0) begin
               $error("result with no expectation");
               errors++;
            end else begin
               want = drive_queue.pop_front();
               if (got.dir !== want.dir) begin
                  $error("drive_direction expected %0d actual %0d", want.dir, got.dir);
                  errors++;
               end
               if (got.right !== want.right) begin
                  $error("right_duty expected %0d actual %0d", want.right, got.right);
                  errors++;
               end
               if (got.left !== want.left) begin
                  $error("left_duty expected %0d actual %0d", want.left, got.left);
                  errors++;
               end
               if (got.bal !== want.bal) begin
                  $error("is_balanced expected %0d actual %0d", want.bal, got.bal);
                  errors++;
               end
            end
         end
         if (hold) begin
            rsp_tready <= 0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 27;
         end
      end
   end

   // The receiver holds off for a long stretch once.
   initial begin
      wait (stall_go);
      @(posedge clock);
      hold = 1;
      repeat (400) @(posedge clock);
      hold = 0;
   end

   task automatic write_reg(logic [2:0] idx, longint v);
      @(posedge clock);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= v[15:0];
      @(posedge clock);
      csr_wen <= 0;
      case (idx)
         blf_pid_pkg::REG_PGP: gp = v[15:0];
         blf_pid_pkg::REG_PGI: gi = v[15:0];
         blf_pid_pkg::REG_PGD: gd = v[15:0];
         blf_pid_pkg::REG_YGP: yp = v[15:0];
         blf_pid_pkg::REG_YGI: yi = v[15:0];
         blf_pid_pkg::REG_YGD: yd = v[15:0];
         blf_pid_pkg::REG_PTGT: ptgt = $signed(v[15:0]);
         blf_pid_pkg::REG_FBM: fbm = v[14:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (tick_queue.size() > 0 || req_tvalid || drive_queue.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [79:0] make_tick(logic [15:0] a, logic [11:0] s0, logic [11:0] s1,
                                             logic [11:0] s2, logic [11:0] s3, logic [11:0] s4);
      return {s4, s3, s2, s1, s0, a};
   endfunction

   function automatic logic [11:0] rand_sensor();
      case ($urandom_range(3))
         0: return 12'($urandom_range(4095));
         1: return 12'd1228 + 12'($urandom_range(2));
         2: return 12'($urandom_range(800));
         default: return 12'd2000 + 12'($urandom_range(2095));
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(3))
         0: return 16'($urandom_range(65535));
         1: return 16'($signed(ptgt) + $signed(17'($urandom_range(600)) - 17'sd300));
         default: return 16'($signed(ptgt) + $signed(17'($urandom_range(5000)) - 17'sd4000));
      endcase
   endfunction

   initial begin
      gp = 2560; gi = 0; gd = 1792; yp = 1434; yi = 0; yd = 435; ptgt = 0; fbm = 4608;
      flag = 0; last_perr = 0; pint = 0; last_yerr = 0; yint = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);
      tick_queue.push_back(make_tick(16'h0000, 0, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(16'h0000, 4095, 4095, 4095, 4095, 4095));
      tick_queue.push_back(make_tick(16'h0040, 1228, 1229, 1230, 0, 4095));
      tick_queue.push_back(make_tick(16'h8000, 0, 4095, 0, 4095, 0));
      tick_queue.push_back(make_tick(16'h7fff, 1229, 0, 1229, 1229, 4095));
      tick_queue.push_back(make_tick(16'h0000, 4095, 4095, 4095, 4095, 0));
      tick_queue.push_back(make_tick(16'h0000, 0, 4095, 4095, 4095, 4095));
      tick_queue.push_back(make_tick(16'hfe00, 4095, 4095, 0, 4095, 4095));
      tick_queue.push_back(make_tick(16'h0000, 0, 0, 4095, 4095, 4095));
      tick_queue.push_back(make_tick(16'h0100, 4095, 4095, 4095, 0, 0));
      tick_queue.push_back(make_tick(16'hff00, 4095, 4095, 4095, 4095, 4095));
      tick_queue.push_back(make_tick(16'h0101, 2048, 2048, 2048, 2048, 2048));
      tick_queue.push_back(make_tick(16'hfeff, 1000, 1000, 1000, 1000, 1000));
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(blf_pid_pkg::REG_PGP, 65535); write_reg(blf_pid_pkg::REG_PGI, 65535);
               write_reg(blf_pid_pkg::REG_PGD, 65535); write_reg(blf_pid_pkg::REG_YGP, 65535);
               write_reg(blf_pid_pkg::REG_YGI, 65535); write_reg(blf_pid_pkg::REG_YGD, 65535);
               write_reg(blf_pid_pkg::REG_PTGT, 16'h7fff);
               write_reg(blf_pid_pkg::REG_FBM, 32767);
            end
            1: begin
               write_reg(blf_pid_pkg::REG_PGP, 0); write_reg(blf_pid_pkg::REG_PGI, 0);
               write_reg(blf_pid_pkg::REG_PGD, 0); write_reg(blf_pid_pkg::REG_YGP, 0);
               write_reg(blf_pid_pkg::REG_YGI, 0); write_reg(blf_pid_pkg::REG_YGD, 0);
               write_reg(blf_pid_pkg::REG_PTGT, 16'h8000); write_reg(blf_pid_pkg::REG_FBM, 0);
            end
            2: begin
               write_reg(blf_pid_pkg::REG_PGP, 2560); write_reg(blf_pid_pkg::REG_PGI, 40);
               write_reg(blf_pid_pkg::REG_PGD, 1792); write_reg(blf_pid_pkg::REG_YGP, 1434);
               write_reg(blf_pid_pkg::REG_YGI, 30); write_reg(blf_pid_pkg::REG_YGD, 435);
               write_reg(blf_pid_pkg::REG_PTGT, 0); write_reg(blf_pid_pkg::REG_FBM, 4608);
            end
            3: begin
               for (int r = 0; r < 6; r++) write_reg(3'(r), $urandom_range(65535));
               write_reg(blf_pid_pkg::REG_PTGT, $urandom_range(65535));
               write_reg(blf_pid_pkg::REG_FBM, $urandom_range(32767));
            end
            default: begin
               write_reg(blf_pid_pkg::REG_PGP, 600); write_reg(blf_pid_pkg::REG_PGI, 5);
               write_reg(blf_pid_pkg::REG_PGD, 300); write_reg(blf_pid_pkg::REG_YGP, 800);
               write_reg(blf_pid_pkg::REG_YGI, 10); write_reg(blf_pid_pkg::REG_YGD, 200);
               write_reg(blf_pid_pkg::REG_PTGT, 16'hff00);
               write_reg(blf_pid_pkg::REG_FBM, 1024);
            end
         endcase
         calm = (ph == 2);
         if (ph == 3) stall_go = 1;
         for (int n = 0; n < 90; n++)
            tick_queue.push_back(make_tick(rand_angle(), rand_sensor(), rand_sensor(),
                                           rand_sensor(), rand_sensor(), rand_sensor()));
         drain();
      end
      if (errors == 0 && drive_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
